/* rtl/core/fac_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the binary32 accumulator calculator.
// No dependencies; used by float_accumulator_calculator_unit.

package fac_pkg;

    // request codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_SHOW  = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // working mantissa width, exponent width, quotient bits
    localparam int MW = 50;
    localparam int EW = 12;
    localparam int QW = 27;

    localparam logic signed [EW-1:0] MW_S     = EW'(MW);
    localparam logic signed [EW-1:0] BIAS_S   = EW'(127);
    localparam logic signed [EW-1:0] MUL_ADJ  = EW'(126);
    localparam logic signed [EW-1:0] EXP_OVF  = EW'(255);
    localparam logic signed [EW-1:0] ONE_S    = EW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ADD,
        ST_MUL,
        ST_DNORM,
        ST_DIV,
        ST_NORM,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/float_accumulator_calculator_unit.sv */
`timescale 1ns / 1ps
// Binary32 accumulator calculator: sequencer, shared adder and normalize/round.
// Depends on fac_pkg.

// Keeps one binary32 accumulator (reset +0.0) and applies add, subtract,
// multiply or divide of the operand to it with round-to-nearest-even and full
// subnormal support; any NaN result is the canonical quiet NaN 0x7FC00000.
// Show, clear, unknown codes and special-value cases go straight to the result state without arithmetic.
// Arithmetic runs through one shared adder: add/sub aligns (shifting one bit a
// cycle), adds, then normalizes; multiply runs 24 shift-add steps then
// normalization; divide runs up to 23 operand normalize steps, 27 restoring
// steps, then normalization.
// One request is in flight at a time; o_in_stall stays high until its result
// has been taken.
module float_accumulator_calculator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_operand,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_acc_value,
    output logic        o_is_display,
    output logic        o_bad_operator
);

    localparam int MW = fac_pkg::MW;
    localparam int EW = fac_pkg::EW;
    localparam int QW = fac_pkg::QW;

    fac_pkg::t_state r_state, n_state;

    logic [31:0]          r_acc, n_acc;
    logic [31:0]          r_res, n_res;
    logic                 r_disp, n_disp;
    logic                 r_bad, n_bad;
    logic [MW-1:0]        r_x, n_x;
    logic [MW-1:0]        r_y, n_y;
    logic [QW-1:0]        r_q, n_q;
    logic [7:0]           r_cnt, n_cnt;
    logic signed [EW-1:0] r_e, n_e;
    logic signed [EW-1:0] r_eb, n_eb;
    logic                 r_sign, n_sign;
    logic                 r_zsign, n_zsign;
    logic                 r_sub, n_sub;

    // operand decode
    logic                 in_acc;
    logic                 sa, sb, sbe, sx;
    logic                 nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [23:0]          ma, mb;
    logic signed [EW-1:0] ea, eb;
    logic                 swap;
    logic [23:0]          m_l, m_s;
    logic signed [EW-1:0] e_l, e_s, d_exp;
    logic                 special;
    logic [31:0]          spec_res;

    // shared adder
    logic [MW-1:0] add_a, add_b;
    logic          add_sub;
    logic [MW:0]   add_sum;

    // divide step
    logic          q_bit;
    logic [MW-1:0] rem;
    logic [QW-1:0] q_next;

    // normalize and round
    logic                 nz_zero, nz_right, nz_left;
    logic [23:0]          rtop;
    logic                 rguard, rsticky, rinc;
    logic [24:0]          rsum;
    logic signed [EW-1:0] rexp;
    logic [31:0]          rounded;

    assign in_acc = i_in_valid && !o_in_stall;

    always_comb begin
        sa     = r_acc[31];
        sb     = i_operand[31];
        sbe    = sb ^ (i_req_type == fac_pkg::OP_SUB);
        sx     = sa ^ sb;
        nan_a  = (r_acc[30:23] == fac_pkg::EXP_MAX) && (r_acc[22:0] != 23'd0);
        nan_b  = (i_operand[30:23] == fac_pkg::EXP_MAX) && (i_operand[22:0] != 23'd0);
        inf_a  = (r_acc[30:23] == fac_pkg::EXP_MAX) && (r_acc[22:0] == 23'd0);
        inf_b  = (i_operand[30:23] == fac_pkg::EXP_MAX) && (i_operand[22:0] == 23'd0);
        zero_a = (r_acc[30:0] == 31'd0);
        zero_b = (i_operand[30:0] == 31'd0);
        ma     = {(r_acc[30:23] != 8'd0), r_acc[22:0]};
        mb     = {(i_operand[30:23] != 8'd0), i_operand[22:0]};
        ea     = (r_acc[30:23] == 8'd0) ? fac_pkg::ONE_S
                                        : $signed({4'b0, r_acc[30:23]});
        eb     = (i_operand[30:23] == 8'd0) ? fac_pkg::ONE_S
                                            : $signed({4'b0, i_operand[30:23]});
        swap   = i_operand[30:0] > r_acc[30:0];
        m_l    = swap ? mb : ma;
        m_s    = swap ? ma : mb;
        e_l    = swap ? eb : ea;
        e_s    = swap ? ea : eb;
        d_exp  = e_l - e_s;
    end

    // results known without arithmetic
    always_comb begin
        special  = 1'b1;
        spec_res = r_acc;
        case (i_req_type)
            fac_pkg::OP_ADD, fac_pkg::OP_SUB: begin
                if (nan_a || nan_b || (inf_a && inf_b && (sa != sbe)))
                    spec_res = fac_pkg::CANON_NAN;
                else if (inf_a)
                    spec_res = {sa, fac_pkg::EXP_MAX, 23'd0};
                else if (inf_b)
                    spec_res = {sbe, fac_pkg::EXP_MAX, 23'd0};
                else
                    special = 1'b0;
            end
            fac_pkg::OP_MUL: begin
                if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b))
                    spec_res = fac_pkg::CANON_NAN;
                else if (inf_a || inf_b)
                    spec_res = {sx, fac_pkg::EXP_MAX, 23'd0};
                else if (zero_a || zero_b)
                    spec_res = {sx, 31'd0};
                else
                    special = 1'b0;
            end
            fac_pkg::OP_DIV: begin
                if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b))
                    spec_res = fac_pkg::CANON_NAN;
                else if (inf_a || zero_b)
                    spec_res = {sx, fac_pkg::EXP_MAX, 23'd0};
                else if (inf_b || zero_a)
                    spec_res = {sx, 31'd0};
                else
                    special = 1'b0;
            end
            fac_pkg::OP_CLEAR: spec_res = 32'd0;
            default:           spec_res = r_acc;
        endcase
    end

    always_comb begin
        add_a   = r_x;
        add_b   = r_y;
        add_sub = 1'b0;
        case (r_state)
            fac_pkg::ST_ADD: add_sub = r_sub;
            fac_pkg::ST_MUL: begin
                add_a = {r_x[MW-2:0], 1'b0};
                add_b = r_q[QW-1] ? r_y : '0;
            end
            fac_pkg::ST_DIV: add_sub = 1'b1;
            default: add_sub = 1'b0;
        endcase
    end

    assign add_sum = {1'b0, add_a} + ({1'b0, add_b} ^ {(MW+1){add_sub}})
                   + {{MW{1'b0}}, add_sub};

    always_comb begin
        q_bit  = !add_sum[MW];
        rem    = q_bit ? add_sum[MW-1:0] : r_x;
        q_next = {r_q[QW-2:0], q_bit};
    end

    always_comb begin
        nz_zero  = (r_x == '0);
        nz_right = (r_e < fac_pkg::ONE_S);
        nz_left  = !r_x[MW-1] && (r_e > fac_pkg::ONE_S);
        rtop     = r_x[MW-1:MW-24];
        rguard   = r_x[MW-25];
        rsticky  = |r_x[MW-26:0];
        rinc     = rguard && (rsticky || rtop[0]);
        rsum     = {1'b0, rtop} + {24'd0, rinc};
        rexp     = rsum[24] ? (r_e + fac_pkg::ONE_S) : (rsum[23] ? r_e : '0);
        if (rexp >= fac_pkg::EXP_OVF)
            rounded = {r_sign, fac_pkg::EXP_MAX, 23'd0};
        else
            rounded = {r_sign, rexp[7:0], (rsum[24] ? 23'd0 : rsum[22:0])};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fac_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type[2] || special)
                        n_state = fac_pkg::ST_DONE;
                    else if (i_req_type == fac_pkg::OP_MUL)
                        n_state = fac_pkg::ST_MUL;
                    else if (i_req_type == fac_pkg::OP_DIV)
                        n_state = fac_pkg::ST_DNORM;
                    else
                        n_state = fac_pkg::ST_ALIGN;
                end
            end
            fac_pkg::ST_ALIGN: if (r_cnt == 8'd0) n_state = fac_pkg::ST_ADD;
            fac_pkg::ST_ADD:   n_state = fac_pkg::ST_NORM;
            fac_pkg::ST_MUL:   if (r_cnt == 8'd1) n_state = fac_pkg::ST_NORM;
            fac_pkg::ST_DNORM: if (r_x[23] && r_y[23]) n_state = fac_pkg::ST_DIV;
            fac_pkg::ST_DIV:   if (r_cnt == 8'd1) n_state = fac_pkg::ST_NORM;
            fac_pkg::ST_NORM:  if (nz_zero || (!nz_right && !nz_left))
                                   n_state = fac_pkg::ST_DONE;
            fac_pkg::ST_DONE:  if (!i_out_stall) n_state = fac_pkg::ST_IDLE;
            default:           n_state = fac_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_acc   = r_acc;
        n_res   = r_res;
        n_disp  = r_disp;
        n_bad   = r_bad;
        n_x     = r_x;
        n_y     = r_y;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_e     = r_e;
        n_eb    = r_eb;
        n_sign  = r_sign;
        n_zsign = r_zsign;
        n_sub   = r_sub;
        case (r_state)
            fac_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_disp = (i_req_type == fac_pkg::OP_SHOW);
                    n_bad  = (i_req_type[2:1] == 2'b11);
                    n_res  = spec_res;
                    if (i_req_type[2] || special)
                        n_acc = spec_res;
                    case (i_req_type)
                        fac_pkg::OP_MUL: begin
                            n_x     = '0;
                            n_y     = {{(MW-26){1'b0}}, mb, 2'b00};
                            n_q     = {ma, {(QW-24){1'b0}}};
                            n_cnt   = 8'd24;
                            n_e     = ea + eb - fac_pkg::MUL_ADJ;
                            n_sign  = sx;
                            n_zsign = sx;
                        end
                        fac_pkg::OP_DIV: begin
                            n_x     = {{(MW-24){1'b0}}, ma};
                            n_y     = {{(MW-24){1'b0}}, mb};
                            n_e     = ea;
                            n_eb    = eb;
                            n_sign  = sx;
                            n_zsign = sx;
                        end
                        default: begin
                            n_x = {1'b0, m_l, {(MW-25){1'b0}}};
                            if (d_exp >= fac_pkg::MW_S) begin
                                n_y   = {{(MW-1){1'b0}}, (m_s != 24'd0)};
                                n_cnt = 8'd0;
                            end else begin
                                n_y   = {1'b0, m_s, {(MW-25){1'b0}}};
                                n_cnt = d_exp[7:0];
                            end
                            n_e     = e_l + fac_pkg::ONE_S;
                            n_sign  = swap ? sbe : sa;
                            n_sub   = sa ^ sbe;
                            n_zsign = sa && sbe;
                        end
                    endcase
                end
            end
            fac_pkg::ST_ALIGN: begin
                if (r_cnt != 8'd0) begin
                    // shift right, fold lost bits into the sticky bit
                    n_y   = {1'b0, r_y[MW-1:2], r_y[1] | r_y[0]};
                    n_cnt = r_cnt - 8'd1;
                end
            end
            fac_pkg::ST_ADD: n_x = add_sum[MW-1:0];
            fac_pkg::ST_MUL: begin
                n_x   = add_sum[MW-1:0];
                n_q   = {r_q[QW-2:0], 1'b0};
                n_cnt = r_cnt - 8'd1;
            end
            fac_pkg::ST_DNORM: begin
                if (!r_x[23]) begin
                    n_x = {r_x[MW-2:0], 1'b0};
                    n_e = r_e - fac_pkg::ONE_S;
                end
                if (!r_y[23]) begin
                    n_y  = {r_y[MW-2:0], 1'b0};
                    n_eb = r_eb - fac_pkg::ONE_S;
                end
                if (r_x[23] && r_y[23]) begin
                    n_e   = r_e - r_eb + fac_pkg::BIAS_S;
                    n_cnt = 8'(QW);
                    n_q   = '0;
                end
            end
            fac_pkg::ST_DIV: begin
                n_q   = q_next;
                n_x   = {rem[MW-2:0], 1'b0};
                n_cnt = r_cnt - 8'd1;
                if (r_cnt == 8'd1)
                    n_x = {q_next, (rem != '0), {(MW-QW-1){1'b0}}};
            end
            fac_pkg::ST_NORM: begin
                if (nz_zero) begin
                    n_res = {r_zsign, 31'd0};
                    n_acc = {r_zsign, 31'd0};
                end else if (nz_right) begin
                    if (r_e < -fac_pkg::MW_S) begin
                        n_x = {{(MW-1){1'b0}}, 1'b1};
                        n_e = fac_pkg::ONE_S;
                    end else begin
                        n_x = {1'b0, r_x[MW-1:2], r_x[1] | r_x[0]};
                        n_e = r_e + fac_pkg::ONE_S;
                    end
                end else if (nz_left) begin
                    n_x = {r_x[MW-2:0], 1'b0};
                    n_e = r_e - fac_pkg::ONE_S;
                end else begin
                    n_res = rounded;
                    n_acc = rounded;
                end
            end
            default: n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fac_pkg::ST_IDLE;
            r_acc   <= 32'd0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_disp  <= n_disp;
        r_bad   <= n_bad;
        r_x     <= n_x;
        r_y     <= n_y;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_e     <= n_e;
        r_eb    <= n_eb;
        r_sign  <= n_sign;
        r_zsign <= n_zsign;
        r_sub   <= n_sub;
    end

    // outputs
    always_comb begin
        o_in_stall     = (r_state != fac_pkg::ST_IDLE);
        o_out_valid    = (r_state == fac_pkg::ST_DONE);
        o_acc_value    = r_res;
        o_is_display   = r_disp;
        o_bad_operator = r_bad;
    end

    a_busy_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input side is open");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in flight");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_display && o_bad_operator))
        else $error("display and bad operator both set");

    a_result_is_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_acc_value == r_acc))
        else $error("result differs from stored accumulator");

endmodule

/* bench/float_accumulator_calculator_checker.sv */
`timescale 1ns / 1ps
// Checker for the binary32 accumulator calculator: watches both channels,
// predicts each result in double precision rounded to binary32 and compares. Depends on fac_pkg.

module float_accumulator_calculator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_operand,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_acc_value,
    input  logic        i_is_display,
    input  logic        i_bad_operator,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [31:0] acc;
        logic        disp;
        logic        bad;
    } t_acc_result;

    t_acc_result acc_result_q[$];
    logic [31:0] acc_shadow;

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        acc_shadow   = 32'h0;
    end

    assign o_pending = acc_result_q.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [63:0] widen(input logic [31:0] f);
        logic [23:0] m24;
        int          ex;
        m24 = {1'b0, f[22:0]};
        if (f[30:23] == 8'h00 && f[22:0] == 0) return {f[31], 63'b0};
        if (f[30:23] == fac_pkg::EXP_MAX) return {f[31], 11'h7FF, f[22:0], 29'b0};
        if (f[30:23] == 8'h00) begin
            ex = -126;
            while (!m24[23]) begin
                m24 = m24 << 1;
                ex--;
            end
        end else begin
            m24 = {1'b1, f[22:0]};
            ex  = int'(f[30:23]) - 127;
        end
        return {f[31], 11'(ex + 1023), m24[22:0], 29'b0};
    endfunction

    // round a double down to binary32, nearest-even, subnormals kept
    function automatic logic [31:0] narrow(input logic [63:0] d);
        logic [63:0] sig, kept, rem, half;
        int          fe, drop;
        if (d[62:52] == 0) return {d[63], 31'b0};
        fe   = int'(d[62:52]) - 1023 + 127;
        sig  = {11'b0, 1'b1, d[51:0]};
        drop = (fe >= 1) ? 29 : 29 + 1 - fe;
        if (drop > 60) drop = 60;
        kept = sig >> drop;
        rem  = sig & ((64'd1 << drop) - 1);
        half = 64'd1 << (drop - 1);
        if (rem > half || (rem == half && kept[0])) kept++;
        if (fe < 1) return {d[63], kept[30:0]};
        if (kept[24]) begin
            kept = kept >> 1;
            fe++;
        end
        if (fe >= 255) return {d[63], fac_pkg::EXP_MAX, 23'b0};
        return {d[63], fe[7:0], kept[22:0]};
    endfunction

    function automatic logic [31:0] fp_arith(input logic [2:0] op,
                                             input logic [31:0] a, input logic [31:0] b);
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
        logic [31:0] bb;
        real         ra, rb, rr;
        bb     = (op == fac_pkg::OP_SUB) ? {~b[31], b[30:0]} : b;
        a_nan  = a[30:23] == fac_pkg::EXP_MAX && a[22:0] != 0;
        b_nan  = b[30:23] == fac_pkg::EXP_MAX && b[22:0] != 0;
        a_inf  = a[30:0] == {fac_pkg::EXP_MAX, 23'b0};
        b_inf  = b[30:0] == {fac_pkg::EXP_MAX, 23'b0};
        a_zero = a[30:0] == 0;
        b_zero = b[30:0] == 0;
        sx     = a[31] ^ b[31];
        if (a_nan || b_nan) return fac_pkg::CANON_NAN;
        case (op)
            fac_pkg::OP_ADD, fac_pkg::OP_SUB: begin
                if (a_inf && b_inf && a[31] != bb[31]) return fac_pkg::CANON_NAN;
                if (a_inf) return a;
                if (b_inf) return bb;
            end
            fac_pkg::OP_MUL: begin
                if (a_inf || b_inf)
                    return (a_zero || b_zero) ? fac_pkg::CANON_NAN
                                              : {sx, fac_pkg::EXP_MAX, 23'b0};
            end
            default: begin
                if (a_inf && b_inf) return fac_pkg::CANON_NAN;
                if (a_inf) return {sx, fac_pkg::EXP_MAX, 23'b0};
                if (b_inf) return {sx, 31'b0};
                if (b_zero)
                    return a_zero ? fac_pkg::CANON_NAN : {sx, fac_pkg::EXP_MAX, 23'b0};
            end
        endcase
        ra = $bitstoreal(widen(a));
        rb = $bitstoreal(widen(bb));
        case (op)
            fac_pkg::OP_ADD, fac_pkg::OP_SUB: rr = ra + rb;
            fac_pkg::OP_MUL:                  rr = ra * rb;
            default:                          rr = ra / rb;
        endcase
        return narrow($realtobits(rr));
    endfunction

    always @(posedge i_clk) begin
        t_acc_result want;
        if (!i_rst_n) begin
            acc_shadow <= 32'h0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                want.disp = i_req_type == fac_pkg::OP_SHOW;
                want.bad  = i_req_type > fac_pkg::OP_CLEAR;
                case (i_req_type)
                    fac_pkg::OP_ADD, fac_pkg::OP_SUB, fac_pkg::OP_MUL, fac_pkg::OP_DIV:
                        want.acc = fp_arith(i_req_type, acc_shadow, i_operand);
                    fac_pkg::OP_CLEAR: want.acc = 32'h0;
                    default:           want.acc = acc_shadow;
                endcase
                acc_shadow <= want.acc;
                acc_result_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (acc_result_q.size() == 0) begin
                    report_mismatch("unexpected result", i_acc_value, 32'h0);
                end else begin
                    want = acc_result_q.pop_front();
                    o_checked++;
                    if (i_acc_value !== want.acc)
                        report_mismatch("acc_value", i_acc_value, want.acc);
                    if (i_is_display !== want.disp)
                        report_mismatch("is_display", 32'(i_is_display), 32'(want.disp));
                    if (i_bad_operator !== want.bad)
                        report_mismatch("bad_operator", 32'(i_bad_operator), 32'(want.bad));
                end
            end
        end
    end

endmodule

/* bench/float_accumulator_calculator_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the accumulator calculator bench: clock, reset, request stimulus,
// idling phases and verdict. Depends on fac_pkg and the checker module.

module float_accumulator_calculator_unit_tb;

    localparam logic [2:0] OP_BAD_A = 3'd6;
    localparam logic [2:0] OP_BAD_B = 3'd7;
    localparam int         HOLD_OFF_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_req_type = fac_pkg::OP_SHOW;
    logic [31:0] i_operand = 32'h0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall, o_out_valid, o_is_display, o_bad_operator;
    logic [31:0] o_acc_value;
    int          fail_count, pending, checked;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_off_go = 1'b0;
    logic        hold_off_done = 1'b0;
    int          hold_off_count = 0;
    int          sent = 0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
    } t_request;
    t_request request_q[$];

    always #1 i_clk = ~i_clk;

    float_accumulator_calculator_unit dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_req_type, .i_operand,
        .o_out_valid, .i_out_stall, .o_acc_value, .o_is_display, .o_bad_operator
    );

    float_accumulator_calculator_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_req_type,
        .i_operand, .i_out_valid(o_out_valid), .i_out_stall, .i_acc_value(o_acc_value),
        .i_is_display(o_is_display), .i_bad_operator(o_bad_operator),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stall, or one long hold-off once it is requested
    always @(posedge i_clk) begin
        if (hold_off_go && !hold_off_done) begin
            i_out_stall <= 1'b1;
            hold_off_count <= hold_off_count + 1;
            if (hold_off_count == HOLD_OFF_CYCLES - 1)
                hold_off_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // sender: drain the request queue, raising valid again only after the last request was taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                i_in_valid <= 1'b0;
                sent <= sent + 1;
            end else if (!i_in_valid && request_q.size() != 0
                         && $urandom_range(99) >= send_idle_pct) begin
                t_request r;
                r = request_q.pop_front();
                i_req_type <= r.kind;
                i_operand  <= r.value;
                i_in_valid <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return {1'($urandom_range(1)), 31'h0};
            1: return {1'($urandom_range(1)), fac_pkg::EXP_MAX, 23'h0};
            2: return {1'($urandom_range(1)), fac_pkg::EXP_MAX,
                       23'($urandom_range(1, 32'h7FFFFF))};
            3: return {1'($urandom_range(1)), 8'h00, 23'($urandom())};
            4: return $urandom();
            default: return {1'($urandom_range(1)), 8'($urandom_range(110, 145)),
                             23'($urandom())};
        endcase
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 3'(r % 4);
        if (r < 88) return fac_pkg::OP_SHOW;
        if (r < 94) return fac_pkg::OP_CLEAR;
        return (r < 97) ? OP_BAD_A : OP_BAD_B;
    endfunction

    task automatic queue_request(input logic [2:0] kind, input logic [31:0] value);
        t_request r;
        r.kind  = kind;
        r.value = value;
        request_q.push_back(r);
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) queue_request(pick_kind(), pick_operand());
        while (request_q.size() != 0 || i_in_valid) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, overflow, invalid operations, rounding ties, bad codes
        queue_request(fac_pkg::OP_ADD,   32'h3F80_0000);
        queue_request(fac_pkg::OP_ADD,   32'h7F7F_FFFF);
        queue_request(fac_pkg::OP_MUL,   32'h4000_0000);
        queue_request(fac_pkg::OP_SUB,   32'h7F80_0000);
        queue_request(fac_pkg::OP_SHOW,  32'hFFFF_FFFF);
        queue_request(fac_pkg::OP_CLEAR, 32'h1234_5678);
        queue_request(fac_pkg::OP_DIV,   32'h0000_0000);
        queue_request(fac_pkg::OP_CLEAR, 32'h0);
        queue_request(fac_pkg::OP_ADD,   32'h0000_0001);
        queue_request(fac_pkg::OP_MUL,   32'h3F00_0000);
        queue_request(fac_pkg::OP_ADD,   32'h807F_FFFF);
        queue_request(fac_pkg::OP_SUB,   32'h8000_0000);
        queue_request(fac_pkg::OP_ADD,   32'h3F80_0000);
        queue_request(fac_pkg::OP_DIV,   32'h0000_0000);
        queue_request(fac_pkg::OP_CLEAR, 32'h0);
        queue_request(fac_pkg::OP_ADD,   32'hBF80_0000);
        queue_request(fac_pkg::OP_DIV,   32'h0000_0000);
        queue_request(OP_BAD_A,          32'hFFFF_FFFF);
        queue_request(OP_BAD_B,          32'h0);
        queue_request(fac_pkg::OP_MUL,   32'h0000_0000);
        queue_request(fac_pkg::OP_CLEAR, 32'h0);
        queue_request(fac_pkg::OP_ADD,   32'hFFFF_FFFF);
        queue_request(fac_pkg::OP_CLEAR, 32'h0);
        queue_request(fac_pkg::OP_ADD,   32'h0080_0000);
        queue_request(fac_pkg::OP_DIV,   32'h4B00_0001);
        while (request_q.size() != 0 || i_in_valid) @(posedge i_clk);

        run_phase(250, 0, 0);
        run_phase(250, 59, 0);
        hold_off_go = 1'b1;
        run_phase(250, 0, 59);
        run_phase(250, 27, 27);
        run_phase(125, 0, 0);

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests, %0d results checked (arith, show, clear, bad codes)",
                 sent, checked);
        $display("idling phases: none, sender idle, receiver stall with hold-off, both");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
